// ===== hdl/bjcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bjcl_pkg
// Shared widths, types and constants for the Barth-Jespersen cell limiter.
// ----------------------------------------------------------------------------
package bjcl_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned FACTOR_W  = FRAC_W + 1;
  localparam int unsigned DIV_STEPS = FRAC_W;
  // lane latency: one setup register plus one register per quotient bit
  localparam int unsigned LANE_LAT  = DIV_STEPS + 1;
  // input reg, min/max reg, lanes, merge reg, product reg, output reg
  localparam int unsigned PIPE_DEPTH = LANE_LAT + 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [FACTOR_W-1:0]      factor_t;

  localparam factor_t Q_ONE = factor_t'(1) << FRAC_W;

endpackage

// ===== hdl/bjcl_ratio_lane.sv =====
// ----------------------------------------------------------------------------
// bjcl_ratio_lane
// One edge: headroom over increment magnitude in Q1.16, capped at one,
// by a pipelined restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module bjcl_ratio_lane (
  input  logic             clk_i,
  input  logic             en_i,
  input  bjcl_pkg::data_t  center_i,
  input  bjcl_pkg::data_t  hi_i,
  input  bjcl_pkg::data_t  lo_i,
  input  bjcl_pkg::data_t  inc_i,
  output bjcl_pkg::factor_t ratio_o
);
  import bjcl_pkg::*;

  logic                  pos, neg;
  logic [DATA_W:0]       head, mag;
  logic                  one_d;

  logic [DATA_W-1:0]     r_q   [0:DIV_STEPS];
  logic [DATA_W-1:0]     mag_q [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]  quo_q [0:DIV_STEPS];
  logic                  one_q [0:DIV_STEPS];

  // setup: pick headroom and magnitude by sign of the increment
  always_comb begin
    pos = !inc_i[DATA_W-1] && (inc_i != '0);
    neg = inc_i[DATA_W-1];
    if (pos) begin
      head = {hi_i[DATA_W-1], hi_i} - {center_i[DATA_W-1], center_i};
      mag  = {1'b0, inc_i};
    end else begin
      head = {center_i[DATA_W-1], center_i} - {lo_i[DATA_W-1], lo_i};
      mag  = {1'b0, ~inc_i} + {{DATA_W{1'b0}}, 1'b1};
    end
    one_d = !(pos || neg) || (head >= mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= head[DATA_W-1:0];
      mag_q[0] <= mag[DATA_W-1:0];
      quo_q[0] <= '0;
      one_q[0] <= one_d;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DATA_W:0] t, diff;
    logic            ge;
    always_comb begin
      t    = {r_q[k], 1'b0};
      ge   = t >= {1'b0, mag_q[k]};
      diff = t - {1'b0, mag_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? diff[DATA_W-1:0] : t[DATA_W-1:0];
        mag_q[k+1] <= mag_q[k];
        quo_q[k+1] <= {quo_q[k][DIV_STEPS-2:0], ge};
        one_q[k+1] <= one_q[k];
      end
    end
  end

  assign ratio_o = one_q[DIV_STEPS] ? Q_ONE : {1'b0, quo_q[DIV_STEPS]};

endmodule

// ===== hdl/bjcl_merge.sv =====
// ----------------------------------------------------------------------------
// bjcl_merge
// Combines the lane ratios into the cell factor (least ratio, or one when
// the limiter is off) and registers it.
// ----------------------------------------------------------------------------
module bjcl_merge (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              lim_en_i,
  input  bjcl_pkg::factor_t ratio_i [bjcl_pkg::LANES],
  output bjcl_pkg::factor_t factor_o
);
  import bjcl_pkg::*;

  factor_t m01, m23, mall;
  factor_t factor_q;

  // two-level minimum tree
  always_comb begin
    m01  = (ratio_i[1] < ratio_i[0]) ? ratio_i[1] : ratio_i[0];
    m23  = (ratio_i[3] < ratio_i[2]) ? ratio_i[3] : ratio_i[2];
    mall = (m23 < m01) ? m23 : m01;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      factor_q <= lim_en_i ? mall : Q_ONE;
    end
  end

  assign factor_o = factor_q;

endmodule

// ===== hdl/bjcl_face.sv =====
// ----------------------------------------------------------------------------
// bjcl_face
// One face: center + floor(factor * increment / 2^16), saturated to 32 bits.
// ----------------------------------------------------------------------------
module bjcl_face (
  input  logic              clk_i,
  input  logic              en_i,
  input  bjcl_pkg::factor_t factor_i,
  input  bjcl_pkg::data_t   center_i,
  input  bjcl_pkg::data_t   inc_i,
  output bjcl_pkg::data_t   face_o
);
  import bjcl_pkg::*;

  localparam int unsigned PROD_W = FACTOR_W + 1 + DATA_W;
  localparam int unsigned SH_W   = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_q;
  data_t                    center_q;
  logic signed [SH_W:0]     sum;
  data_t                    face_q;

  // stage 1: product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= $signed({1'b0, factor_i}) * inc_i;
      center_q <= center_i;
    end
  end

  // stage 2: floor shift, add, saturate
  always_comb begin
    sum = {prod_q[PROD_W-1], prod_q[PROD_W-1:FRAC_W]}
        + {{(SH_W+1-DATA_W){center_q[DATA_W-1]}}, center_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sum > $signed({{(SH_W+1-DATA_W){1'b0}}, {1'b0, {(DATA_W-1){1'b1}}}}))
        face_q <= {1'b0, {(DATA_W-1){1'b1}}};
      else if (sum < $signed({{(SH_W+1-DATA_W){1'b1}}, {1'b1, {(DATA_W-1){1'b0}}}}))
        face_q <= {1'b1, {(DATA_W-1){1'b0}}};
      else
        face_q <= sum[DATA_W-1:0];
    end
  end

  assign face_o = face_q;

endmodule

// ===== hdl/barth_jespersen_cell_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// barth_jespersen_cell_limiter_unit
// Barth-Jespersen limiter for one four-edged cell per transfer.
// ----------------------------------------------------------------------------
// Takes one cell per clock unless stalled and returns one result per cell, in
// order, through 22 register stages: the input register, the min/max register,
// the four ratio lanes, each a setup register and a 16-stage pipelined divider
// producing one quotient bit per stage, and the merge, multiply and saturate
// registers. The whole pipeline holds while a finished result is
// stalled at the output.
// limiter_enable resets to 1 and is written through the cfg channel, which
// is always ready.
module barth_jespersen_cell_limiter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bjcl_pkg::data_t   center_value_i,
  input  bjcl_pkg::data_t   neighbor_value_0_i,
  input  bjcl_pkg::data_t   neighbor_value_1_i,
  input  bjcl_pkg::data_t   neighbor_value_2_i,
  input  bjcl_pkg::data_t   neighbor_value_3_i,
  input  bjcl_pkg::data_t   increment_0_i,
  input  bjcl_pkg::data_t   increment_1_i,
  input  bjcl_pkg::data_t   increment_2_i,
  input  bjcl_pkg::data_t   increment_3_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bjcl_pkg::factor_t limit_factor_o,
  output logic              was_limited_o,
  output bjcl_pkg::data_t   face_value_0_o,
  output bjcl_pkg::data_t   face_value_1_o,
  output bjcl_pkg::data_t   face_value_2_o,
  output bjcl_pkg::data_t   face_value_3_o
);
  import bjcl_pkg::*;

  logic adv;
  logic lim_en_q;
  logic vld_q [0:PIPE_DEPTH-1];

  data_t center0_q, center1_q, lo_q, hi_q;
  data_t nb0_q  [LANES];
  data_t inc0_q [LANES];
  data_t inc1_q [LANES];
  data_t lo_d, hi_d;

  data_t sd_center_q [0:LANE_LAT];
  data_t sd_inc_q    [0:LANE_LAT][LANES];

  factor_t ratio  [LANES];
  factor_t factor;
  factor_t factor1_q, factor2_q;
  data_t   face   [LANES];

  // pipeline advances unless the output holds a stalled result
  assign adv         = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      lim_en_q <= cfg_data_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      center0_q <= center_value_i;
      nb0_q[0]  <= neighbor_value_0_i;
      nb0_q[1]  <= neighbor_value_1_i;
      nb0_q[2]  <= neighbor_value_2_i;
      nb0_q[3]  <= neighbor_value_3_i;
      inc0_q[0] <= increment_0_i;
      inc0_q[1] <= increment_1_i;
      inc0_q[2] <= increment_2_i;
      inc0_q[3] <= increment_3_i;
    end
  end

  // neighborhood min/max including the cell itself
  always_comb begin
    lo_d = center0_q;
    hi_d = center0_q;
    for (int e = 0; e < LANES; e++) begin
      if (nb0_q[e] < lo_d) lo_d = nb0_q[e];
      if (nb0_q[e] > hi_d) hi_d = nb0_q[e];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      center1_q <= center0_q;
      inc1_q    <= inc0_q;
    end
  end

  // side data delay line, aligned with the merged factor
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_center_q[0] <= center1_q;
      sd_inc_q[0]    <= inc1_q;
      for (int k = 1; k <= LANE_LAT; k++) begin
        sd_center_q[k] <= sd_center_q[k-1];
        sd_inc_q[k]    <= sd_inc_q[k-1];
      end
    end
  end

  // ratio lanes
  for (genvar e = 0; e < LANES; e++) begin : g_lane
    bjcl_ratio_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .center_i (center1_q),
      .hi_i     (hi_q),
      .lo_i     (lo_q),
      .inc_i    (inc1_q[e]),
      .ratio_o  (ratio[e])
    );
  end

  bjcl_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (adv),
    .lim_en_i (lim_en_q),
    .ratio_i  (ratio),
    .factor_o (factor)
  );

  // face reconstruction lanes
  for (genvar e = 0; e < LANES; e++) begin : g_face
    bjcl_face u_face (
      .clk_i    (clk_i),
      .en_i     (adv),
      .factor_i (factor),
      .center_i (sd_center_q[LANE_LAT]),
      .inc_i    (sd_inc_q[LANE_LAT][e]),
      .face_o   (face[e])
    );
  end

  // factor follows the face pipeline
  always_ff @(posedge clk_i) begin
    if (adv) begin
      factor1_q <= factor;
      factor2_q <= factor1_q;
    end
  end

  assign out_valid_o    = vld_q[PIPE_DEPTH-1];
  assign limit_factor_o = factor2_q;
  assign was_limited_o  = factor2_q < Q_ONE;
  assign face_value_0_o = face[0];
  assign face_value_1_o = face[1];
  assign face_value_2_o = face[2];
  assign face_value_3_o = face[3];

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Barth-Jespersen cell limiter: a directed table
// of edge cases, then random cells, all compared field by field against an
// in-bench limiter calculation, with random gaps, stalls and one long hold.
// ----------------------------------------------------------------------------
module testbench;
  import bjcl_pkg::*;

  typedef struct packed {
    data_t center;
    data_t nb0, nb1, nb2, nb3;
    data_t inc0, inc1, inc2, inc3;
  } cell_t;

  typedef struct packed {
    factor_t factor;
    logic    limited;
    data_t   f0, f1, f2, f3;
  } limited_t;

  // directed row: cell, optional hand-written result
  typedef struct {
    cell_t    stim;
    logic     has_known;
    limited_t known;
  } row_t;

  localparam data_t DMAX = 32'sh7fffffff;
  localparam data_t DMIN = 32'sh80000000;
  localparam data_t ONE  = 32'sh00010000;
  localparam int    RANDOM_CELLS = 1800;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_valid_i = 1'b0;
  logic    cfg_ready_o;
  logic    cfg_data_i = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  cell_t   cell_q = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b1;
  wire limited_t got;

  logic     enable_mdl = 1'b1;
  limited_t pending_q[$];
  int       errors = 0;
  int       checked = 0;
  int       limited_seen = 0;
  bit       long_hold = 1'b0;
  bit       sender_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  barth_jespersen_cell_limiter_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .center_value_i(cell_q.center),
    .neighbor_value_0_i(cell_q.nb0), .neighbor_value_1_i(cell_q.nb1),
    .neighbor_value_2_i(cell_q.nb2), .neighbor_value_3_i(cell_q.nb3),
    .increment_0_i(cell_q.inc0), .increment_1_i(cell_q.inc1),
    .increment_2_i(cell_q.inc2), .increment_3_i(cell_q.inc3),
    .out_valid_o, .out_stall_i,
    .limit_factor_o(got.factor), .was_limited_o(got.limited),
    .face_value_0_o(got.f0), .face_value_1_o(got.f1),
    .face_value_2_o(got.f2), .face_value_3_o(got.f3)
  );

  // headroom over increment in Q1.16, capped at one
  function automatic longint edge_ratio(longint head, longint mag);
    if (head >= mag) return longint'(Q_ONE);
    return (head <<< FRAC_W) / mag;
  endfunction

  // center + floor(factor * inc / 2^16), clamped to 32 bits
  function automatic data_t face_of(longint center, longint factor, data_t inc);
    longint p;
    longint s;
    p = factor * longint'(inc);
    s = center + (p >>> FRAC_W);
    if (s > longint'(DMAX)) return DMAX;
    if (s < longint'(DMIN)) return DMIN;
    return data_t'(s);
  endfunction

  function automatic limited_t limit_cell(cell_t c, logic en);
    limited_t r;
    longint   lo, hi, ctr, f, q;
    data_t    nb[4];
    data_t    inc[4];
    nb  = '{c.nb0, c.nb1, c.nb2, c.nb3};
    inc = '{c.inc0, c.inc1, c.inc2, c.inc3};
    ctr = c.center;
    lo = ctr;
    hi = ctr;
    f = longint'(Q_ONE);
    foreach (nb[e]) begin
      if (nb[e] < lo) lo = nb[e];
      if (nb[e] > hi) hi = nb[e];
    end
    if (en) begin
      foreach (inc[e]) begin
        q = longint'(Q_ONE);
        if (inc[e] > 0) q = edge_ratio(hi - ctr, longint'(inc[e]));
        else if (inc[e] < 0) q = edge_ratio(ctr - lo, -longint'(inc[e]));
        if (q < f) f = q;
      end
    end
    r.factor  = factor_t'(f);
    r.limited = (f < longint'(Q_ONE));
    r.f0 = face_of(ctr, f, inc[0]);
    r.f1 = face_of(ctr, f, inc[1]);
    r.f2 = face_of(ctr, f, inc[2]);
    r.f3 = face_of(ctr, f, inc[3]);
    return r;
  endfunction

  function automatic data_t rnd_value();
    case ($urandom_range(0, 5))
      0: return data_t'($urandom());
      1: return $urandom_range(0, 1) ? DMAX : DMIN;
      default: return data_t'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
    endcase
  endfunction

  function automatic cell_t rnd_cell();
    cell_t c;
    c.center = rnd_value();
    c.nb0 = rnd_value(); c.nb1 = rnd_value();
    c.nb2 = rnd_value(); c.nb3 = rnd_value();
    c.inc0 = ($urandom_range(0, 7) == 0) ? '0 : rnd_value();
    c.inc1 = ($urandom_range(0, 7) == 0) ? '0 : rnd_value();
    c.inc2 = ($urandom_range(0, 7) == 0) ? '0 : rnd_value();
    c.inc3 = ($urandom_range(0, 7) == 0) ? '0 : rnd_value();
    return c;
  endfunction

  // one cell transfer with a random lead-in gap; valid stays up between
  // back-to-back cells and drops only for a gap
  task automatic send_cell(cell_t c, logic has_known, limited_t known);
    limited_t want;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    want = has_known ? known : limit_cell(c, enable_mdl);
    if (has_known && want != limit_cell(c, enable_mdl))
      $error("directed row disagrees with calculation");
    cell_q <= c;
    in_valid_i <= 1'b1;
    pending_q.push_back(want);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic write_enable(logic v);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    enable_mdl = v;
  endtask

  // receiver: random wait per result, one long hold while the sender keeps
  // offering
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // result check against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        limited_t w;
        w = pending_q.pop_front();
        checked++;
        if (w.limited) limited_seen++;
        if (got.factor !== w.factor) begin
          $error("limit_factor exp %0d got %0d", w.factor, got.factor); errors++;
        end
        if (got.limited !== w.limited) begin
          $error("was_limited exp %0d got %0d", w.limited, got.limited); errors++;
        end
        if (got.f0 !== w.f0) begin
          $error("face_value_0 exp %0d got %0d", w.f0, got.f0); errors++;
        end
        if (got.f1 !== w.f1) begin
          $error("face_value_1 exp %0d got %0d", w.f1, got.f1); errors++;
        end
        if (got.f2 !== w.f2) begin
          $error("face_value_2 exp %0d got %0d", w.f2, got.f2); errors++;
        end
        if (got.f3 !== w.f3) begin
          $error("face_value_3 exp %0d got %0d", w.f3, got.f3); errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    row_t rows[$];
    limited_t k;
    cell_t c;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all increments zero: faces equal the center
    c = '{center: ONE, nb0: 0, nb1: 0, nb2: 0, nb3: 0,
          inc0: 0, inc1: 0, inc2: 0, inc3: 0};
    k = '{factor: Q_ONE, limited: 0, f0: ONE, f1: ONE, f2: ONE, f3: ONE};
    rows.push_back('{c, 1'b1, k});
    // flat neighborhood, nonzero increments: factor zero
    c = '{center: ONE, nb0: ONE, nb1: ONE, nb2: ONE, nb3: ONE,
          inc0: ONE, inc1: -ONE, inc2: DMAX, inc3: DMIN};
    k = '{factor: 0, limited: 1, f0: ONE, f1: ONE, f2: ONE, f3: ONE};
    rows.push_back('{c, 1'b1, k});
    // headroom exactly half the increment
    c = '{center: 0, nb0: ONE, nb1: -ONE, nb2: 0, nb3: 0,
          inc0: 2 * ONE, inc1: 0, inc2: 0, inc3: 0};
    k = '{factor: 17'd32768, limited: 1, f0: ONE, f1: 0, f2: 0, f3: 0};
    rows.push_back('{c, 1'b1, k});
    // extremes of every field
    c = '{center: DMAX, nb0: DMIN, nb1: DMAX, nb2: DMIN, nb3: DMAX,
          inc0: DMAX, inc1: DMIN, inc2: 1, inc3: -1};
    rows.push_back('{c, 1'b0, k});
    c = '{center: DMIN, nb0: DMAX, nb1: DMIN, nb2: DMAX, nb3: DMIN,
          inc0: DMAX, inc1: DMIN, inc2: -1, inc3: 1};
    rows.push_back('{c, 1'b0, k});
    c = '{center: 0, nb0: DMAX, nb1: DMIN, nb2: 5, nb3: -5,
          inc0: 1, inc1: -1, inc2: DMAX, inc3: DMIN};
    rows.push_back('{c, 1'b0, k});
    // unconstrained: ample headroom on every face
    c = '{center: 0, nb0: 4 * ONE, nb1: -4 * ONE, nb2: 0, nb3: 0,
          inc0: ONE, inc1: -ONE, inc2: 3, inc3: -3};
    rows.push_back('{c, 1'b0, k});
    for (int i = 0; i < 8; i++) rows.push_back('{rnd_cell(), 1'b0, k});

    foreach (rows[i]) send_cell(rows[i].stim, rows[i].has_known, rows[i].known);
    wait_drained();
    // limiter off with saturating sums
    write_enable(1'b0);
    c = '{center: DMAX, nb0: 0, nb1: 0, nb2: 0, nb3: 0,
          inc0: ONE, inc1: DMIN, inc2: 0, inc3: -1};
    send_cell(c, 1'b0, k);
    c = '{center: DMIN, nb0: 0, nb1: 0, nb2: 0, nb3: 0,
          inc0: -ONE, inc1: DMAX, inc2: 0, inc3: 1};
    send_cell(c, 1'b0, k);
    wait_drained();
    write_enable(1'b1);

    // random phases, alternating register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) long_hold = 1'b1;
      for (int i = 0; i < RANDOM_CELLS / 6; i++) send_cell(rnd_cell(), 1'b0, k);
      wait_drained();
      write_enable(ph % 2 == 0 ? 1'b0 : 1'b1);
    end
    sender_done = 1'b1;
    wait_drained();

    $display("Checked %0d cells, %0d of them limited, with limiter on and off.",
             checked, limited_seen);
    if (errors == 0 && pending_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bjcl_pkg.sv
hdl/bjcl_ratio_lane.sv
hdl/bjcl_merge.sv
hdl/bjcl_face.sv
hdl/barth_jespersen_cell_limiter_unit.sv
tb/testbench.sv
